// File: rtl/core/bbmr_pkg.sv
// Shared types and constants of the binary box morphology row filter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bbmr_pkg;

  localparam int DATA_W         = 64;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_RADIUS_DEF = 15;

  localparam int RADIUS_W   = 4;
  localparam int WIDTH_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    mode_e                mode;
    logic [RADIUS_W-1:0]  radius;
    logic [WIDTH_W-1:0]   width;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] row_bits;
    logic              last_row;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_bits;
    logic              out_last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/bbmr_hlane.sv
// One lane: horizontal box filter of one stored row, registered.
// Depends on bbmr_pkg for the mode type.
`default_nettype none

module bbmr_hlane #(
  parameter int MAX_WIDTH  = bbmr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bbmr_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic [MAX_WIDTH-1:0]              row_i,
  input  logic [MAX_WIDTH-1:0]              mask_i,
  input  bbmr_pkg::mode_e                   mode_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]   radius_i,
  output logic [MAX_WIDTH-1:0]              hz_o
);
  import bbmr_pkg::*;

  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int WIN = 2 * MAX_RADIUS + 1;

  logic [MAX_WIDTH+2*MAX_RADIUS-1:0] pad;
  logic [WIN-1:0]                    win;
  logic [MAX_WIDTH-1:0]              hz_d;
  logic [MAX_WIDTH-1:0]              hz_q;

  // Columns outside the row read as background on both sides.
  assign pad = {{MAX_RADIUS{1'b0}}, row_i & mask_i, {MAX_RADIUS{1'b0}}};

  for (genvar k = 0; k < WIN; k++) begin : g_win
    localparam int DIST = (k >= MAX_RADIUS) ? (k - MAX_RADIUS) : (MAX_RADIUS - k);
    assign win[k] = (radius_i >= RW'(DIST));
  end

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
    logic any_set;
    logic all_set;
    assign any_set = |(pad[i +: WIN] & win);
    assign all_set = &(pad[i +: WIN] | ~win);
    assign hz_d[i] = mask_i[i] & ((mode_i == MODE_ERODE) ? all_set : any_set);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hz_q <= hz_d;
    end
  end

  assign hz_o = hz_q;

endmodule

`default_nettype wire

// File: rtl/core/bbmr_merge.sv
// Merging stage: combines the selected lane rows vertically and holds the
// output item in a register. Depends on bbmr_pkg for item and mode types.
`default_nettype none

module bbmr_merge #(
  parameter int MAX_WIDTH  = bbmr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bbmr_pkg::MAX_RADIUS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic [2*MAX_RADIUS:0][MAX_WIDTH-1:0]         hz_i,
  input  logic [2*MAX_RADIUS:0]                        sel_i,
  input  logic                                         zero_i,
  input  logic                                         last_i,
  input  bbmr_pkg::mode_e                              mode_i,
  input  logic [MAX_WIDTH-1:0]                         mask_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output bbmr_pkg::out_item_t                          out_item_o
);
  import bbmr_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS + 1;

  logic [MAX_WIDTH-1:0] acc;
  logic                 out_valid_d;
  logic                 out_valid_q;
  out_item_t            out_item_q;
  logic                 load;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
    logic [DEPTH-1:0] col_any;
    logic [DEPTH-1:0] col_all;
    for (genvar a = 0; a < DEPTH; a++) begin : g_row
      assign col_any[a] = hz_i[a][i] & sel_i[a];
      assign col_all[a] = hz_i[a][i] | ~sel_i[a];
    end
    // An erosion window that reaches past the top or bottom edge is clear.
    assign acc[i] = mask_i[i] &
                    ((mode_i == MODE_ERODE) ? (~zero_i & (&col_all)) : (|col_any));
  end

  assign ready_o = !out_valid_q || out_ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q.out_bits <= DATA_W'(acc);
      out_item_q.out_last <= last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: rtl/core/binary_box_morphology_rows.sv
// Binary box morphology on a row-streamed mask; top level.
// Depends on bbmr_pkg, bbmr_hlane and bbmr_merge.
//
// Takes one mask row per item and returns rows filtered by a square dilation
// or erosion window of the configured radius R (saturated at MAX_RADIUS).
// While the output side keeps up, a new row is accepted every cycle. An output
// row is registered in the job and row store, the horizontal lanes and the
// vertical merge in turn after the row completing its window is accepted, and
// one output row can leave per cycle while the output is ready. Until the mask
// has R+1 rows only its last row gives output. The row marked last produces
// min(R, rows-1)+1 output rows, the final one marked; while they are issued
// the input is held, also while the output stalls.
// Each of the 2*MAX_RADIUS+1 stored rows has its own horizontal filter lane.
`default_nettype none

module binary_box_morphology_rows #(
  parameter int MAX_WIDTH  = bbmr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bbmr_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bbmr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbmr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bbmr_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bbmr_pkg::out_item_t                 out_item_o
);
  import bbmr_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = CNT_W + 1;

  // Configuration registers.
  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   cfg_d.mode   = mode_e'(cfg_data_i[0]);
        CFG_RADIUS: cfg_d.radius = cfg_data_i[RADIUS_W-1:0];
        CFG_WIDTH:  cfg_d.width  = cfg_data_i[WIDTH_W-1:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_DILATE;
      cfg_q.radius <= '0;
      cfg_q.width  <= WIDTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic [CW-1:0]        r_eff;
  logic [MAX_WIDTH-1:0] mask;

  assign r_eff = (32'(cfg_q.radius) > MAX_RADIUS) ? CW'(MAX_RADIUS) : CW'(cfg_q.radius);

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
    assign mask[i] = (cfg_q.width > WIDTH_W'(i));
  end

  // Handshake chain: A holds a job, B the lane results, the merge holds C.
  logic a_valid_d, a_valid_q;
  logic b_valid_d, b_valid_q;
  logic merge_ready;
  logic b_ready, a_ready, a_move, accept;

  assign b_ready    = !b_valid_q || merge_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign a_move     = a_valid_q && b_ready;

  logic drain_d, drain_q;
  assign in_ready_o = !drain_q && a_ready;
  assign accept     = in_valid_i && in_ready_o;

  // Row store as a shift line, newest row at age zero.
  logic [MAX_WIDTH-1:0] store_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[0] <= in_item_i.row_bits[MAX_WIDTH-1:0] & mask;
      for (int a = 1; a < DEPTH; a++) begin
        store_q[a] <= store_q[a-1];
      end
    end
  end

  // Job generation, including the drain after the last row.
  logic [CNT_W-1:0] rows_seen_d, rows_seen_q, n_new;
  logic [CW-1:0]    drain_c_d, drain_c_q, c0;
  logic [CNT_W-1:0] drain_n_d, drain_n_q;
  logic [CW-1:0]    a_center_d, a_center_q;
  logic [CNT_W-1:0] a_nrows_d, a_nrows_q;
  logic             a_last_d, a_last_q;

  assign n_new = (rows_seen_q == CNT_W'(DEPTH)) ? rows_seen_q : rows_seen_q + 1'b1;
  assign c0    = (CNT_W'(r_eff) < n_new) ? r_eff : CW'(n_new - 1'b1);

  always_comb begin
    rows_seen_d = rows_seen_q;
    drain_d     = drain_q;
    drain_c_d   = drain_c_q;
    drain_n_d   = drain_n_q;
    a_valid_d   = a_valid_q;
    a_center_d  = a_center_q;
    a_nrows_d   = a_nrows_q;
    a_last_d    = a_last_q;
    priority if (accept) begin
      a_nrows_d = n_new;
      if (!in_item_i.last_row) begin
        rows_seen_d = n_new;
        a_valid_d   = (CNT_W'(r_eff) < n_new);
        a_center_d  = r_eff;
        a_last_d    = 1'b0;
      end else begin
        rows_seen_d = '0;
        a_valid_d   = 1'b1;
        a_center_d  = c0;
        a_last_d    = (c0 == '0);
        drain_d     = (c0 != '0);
        drain_c_d   = c0 - 1'b1;
        drain_n_d   = n_new;
      end
    end else if (drain_q && a_ready) begin
      a_valid_d  = 1'b1;
      a_center_d = drain_c_q;
      a_nrows_d  = drain_n_q;
      a_last_d   = (drain_c_q == '0);
      drain_d    = (drain_c_q != '0);
      drain_c_d  = drain_c_q - 1'b1;
    end else if (a_move) begin
      a_valid_d = 1'b0;
    end else begin
      a_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_seen_q <= '0;
      drain_q     <= 1'b0;
      drain_c_q   <= '0;
      drain_n_q   <= '0;
      a_valid_q   <= 1'b0;
      a_center_q  <= '0;
      a_nrows_q   <= '0;
      a_last_q    <= 1'b0;
    end else begin
      rows_seen_q <= rows_seen_d;
      drain_q     <= drain_d;
      drain_c_q   <= drain_c_d;
      drain_n_q   <= drain_n_d;
      a_valid_q   <= a_valid_d;
      a_center_q  <= a_center_d;
      a_nrows_q   <= a_nrows_d;
      a_last_q    <= a_last_d;
    end
  end

  // Stage B: lane results plus the vertical window selection.
  logic [AW-1:0]    ctr_ext, r_ext, n_ext;
  logic [DEPTH-1:0] sel_d, sel_q;
  logic             b_zero_d, b_zero_q;
  logic             b_last_q;

  assign ctr_ext  = AW'(a_center_q);
  assign r_ext    = AW'(r_eff);
  assign n_ext    = AW'(a_nrows_q);
  assign b_zero_d = (ctr_ext < r_ext) || (ctr_ext + r_ext >= n_ext);

  for (genvar a = 0; a < DEPTH; a++) begin : g_sel
    assign sel_d[a] = (AW'(a) + r_ext >= ctr_ext) && (AW'(a) <= ctr_ext + r_ext) &&
                      (AW'(a) < n_ext);
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (a_move) begin
      b_valid_d = 1'b1;
    end else if (merge_ready) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      sel_q    <= sel_d;
      b_zero_q <= b_zero_d;
      b_last_q <= a_last_q;
    end
  end

  logic [DEPTH-1:0][MAX_WIDTH-1:0] hz;

  for (genvar a = 0; a < DEPTH; a++) begin : g_lane
    bbmr_hlane #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
    ) u_lane (
      .clk_i    (clk_i),
      .load_i   (a_move),
      .row_i    (store_q[a]),
      .mask_i   (mask),
      .mode_i   (cfg_q.mode),
      .radius_i (r_eff),
      .hz_o     (hz[a])
    );
  end

  bbmr_merge #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (b_valid_q),
    .ready_o     (merge_ready),
    .hz_i        (hz),
    .sel_i       (sel_q),
    .zero_i      (b_zero_q),
    .last_i      (b_last_q),
    .mode_i      (cfg_q.mode),
    .mask_i      (mask),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/bbmr_tb_pkg.sv
// Scoreboard for the binary box morphology row filter: predicts filtered rows.
// Depends on bbmr_pkg for the item, mode and register types.
`timescale 1ns / 100ps

package bbmr_tb_pkg;

  import bbmr_pkg::*;

  localparam int unsigned STORE_DEPTH = 2 * MAX_RADIUS_DEF + 1;

  class row_scoreboard;

    logic [DATA_W-1:0]   raw_rows [STORE_DEPTH];
    int unsigned         rows_seen;
    int unsigned         write_slot;
    mode_e               mode;
    logic [RADIUS_W-1:0] radius;
    logic [WIDTH_W-1:0]  width;
    out_item_t           expected_rows [$];
    int unsigned         mismatches;

    function new();
      rows_seen  = 0;
      write_slot = 0;
      mode       = MODE_DILATE;
      radius     = '0;
      width      = WIDTH_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:   mode   = mode_e'(val[0]);
        CFG_RADIUS: radius = val[RADIUS_W-1:0];
        CFG_WIDTH:  width  = val[WIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned radius_in_use();
      return (radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius;
    endfunction

    function logic [DATA_W-1:0] column_mask();
      int unsigned w;
      w = (width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width;
      if (w >= DATA_W) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    // Window along one row; shifted-in columns are background.
    function logic [DATA_W-1:0] row_window(logic [DATA_W-1:0] row, int unsigned r,
                                           logic [DATA_W-1:0] msk);
      logic [DATA_W-1:0] src;
      logic [DATA_W-1:0] acc;
      src = row & msk;
      acc = src;
      for (int unsigned k = 1; k <= r; k++) begin
        if (mode == MODE_ERODE) acc &= (src << k) & (src >> k);
        else acc |= (src << k) | (src >> k);
      end
      return acc & msk;
    endfunction

    // Output row centered at the given age, where age 0 is the newest row.
    function logic [DATA_W-1:0] window_at(int unsigned center, int unsigned r);
      logic [DATA_W-1:0] msk;
      logic [DATA_W-1:0] acc;
      int unsigned lo;
      int unsigned hi;
      int unsigned slot;
      msk = column_mask();
      acc = (mode == MODE_ERODE) ? msk : '0;
      lo  = (center >= r) ? center - r : 0;
      hi  = center + r;
      // Rows above the first or below the last one are background.
      if (mode == MODE_ERODE && (center < r || hi >= rows_seen)) return '0;
      for (int unsigned a = lo; a <= hi; a++) begin
        if (a >= rows_seen) break;
        slot = (write_slot + STORE_DEPTH - 1 - (a % STORE_DEPTH)) % STORE_DEPTH;
        if (mode == MODE_ERODE) acc &= row_window(raw_rows[slot], r, msk);
        else acc |= row_window(raw_rows[slot], r, msk);
      end
      return acc & msk;
    endfunction

    function void queue_expected(out_item_t res);
      expected_rows.insert(expected_rows.size(), res);
    endfunction

    function void note_row(in_item_t it);
      int unsigned r;
      int unsigned c;
      out_item_t   res;
      r = radius_in_use();
      raw_rows[write_slot] = it.row_bits & column_mask();
      write_slot = (write_slot + 1) % STORE_DEPTH;
      if (rows_seen < STORE_DEPTH) rows_seen++;
      if (!it.last_row) begin
        if (r < rows_seen) begin
          res.out_bits = window_at(r, r);
          res.out_last = 1'b0;
          queue_expected(res);
        end
      end else begin
        c = (r < rows_seen) ? r : rows_seen - 1;
        for (int k = int'(c); k >= 0; k--) begin
          res.out_bits = window_at(k, r);
          res.out_last = (k == 0);
          queue_expected(res);
        end
        rows_seen  = 0;
        write_slot = 0;
      end
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected bits %h last %b, got bits %h last %b", what,
                 want.out_bits, want.out_last, got.out_bits, got.out_last);
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      if (expected_rows.size() == 0) begin
        report("unexpected output row", '0, got);
        return;
      end
      want = expected_rows.pop_front();
      if (got.out_bits !== want.out_bits || got.out_last !== want.out_last)
        report("output row mismatch", want, got);
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction

    function void check_end();
      while (expected_rows.size() != 0)
        report("missing output row", expected_rows.pop_front(), '0);
    endfunction

  endclass

endpackage

// File: tb/sv/tb.sv
// Top of the testbench for binary_box_morphology_rows: drives masks and config.
// Depends on bbmr_pkg, bbmr_tb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;

  import bbmr_pkg::*;
  import bbmr_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_WAIT  = 12;
  localparam int unsigned RANDOM_ROWS  = 260;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_ROWS    = 40;

  typedef enum int unsigned {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_style_e;
  typedef enum int unsigned {ROW_RANDOM, ROW_SPARSE, ROW_DENSE, ROW_FULL, ROW_EMPTY} row_style_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we_r;
  cfg_reg_e              cfg_idx_r;
  logic [CFG_DATA_W-1:0] cfg_data_r;
  logic                  in_valid_r;
  logic                  in_ready;
  in_item_t              in_item_r;
  logic                  out_valid;
  logic                  out_ready_r;
  out_item_t             out_item;

  row_scoreboard sb;
  int unsigned   burst_left;
  int unsigned   random_rows;
  int unsigned   cycles;
  bit            hold_req;

  binary_box_morphology_rows u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we_r),
    .cfg_idx_i   (cfg_idx_r),
    .cfg_data_i  (cfg_data_r),
    .in_valid_i  (in_valid_r),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item_r),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready_r),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: items go out in bursts of random length with random gaps.
  task automatic send_row(input logic [DATA_W-1:0] bits, input logic last);
    in_item_t it;
    it.row_bits = bits;
    it.last_row = last;
    if (burst_left == 0) begin
      in_valid_r <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_r <= 1'b1;
    in_item_r  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_row(it);
  endtask

  task automatic wait_idle();
    in_valid_r <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_r   <= 1'b1;
    cfg_idx_r  <= idx;
    cfg_data_r <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_cfg(input mode_e m, input logic [RADIUS_W-1:0] r,
                           input logic [WIDTH_W-1:0] w);
    wait_idle();
    put_reg(CFG_MODE, CFG_DATA_W'(m));
    put_reg(CFG_RADIUS, CFG_DATA_W'(r));
    put_reg(CFG_WIDTH, CFG_DATA_W'(w));
    cfg_we_r <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_row(row_style_e style);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (style)
      ROW_SPARSE: return a & b & c;
      ROW_DENSE:  return ~(a & b & c);
      ROW_FULL:   return '1;
      ROW_EMPTY:  return '0;
      default:    return a;
    endcase
  endfunction

  // Erosion needs nearly full rows to leave anything set; dilation the opposite.
  function automatic row_style_e style_for(mode_e m);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return ROW_RANDOM;
    if (roll == 2) return ROW_EMPTY;
    if (roll == 3) return (m == MODE_ERODE) ? ROW_SPARSE : ROW_FULL;
    if (m == MODE_ERODE) return (roll < 12) ? ROW_DENSE : ROW_FULL;
    return (roll < 14) ? ROW_SPARSE : ROW_RANDOM;
  endfunction

  // Receiver: stall patterns change from stretch to stretch, plus one long hold
  // that starts when the sender asks for it.
  initial begin : rx_side
    int unsigned stretch_left;
    int unsigned hold_left;
    bit          held;
    rx_style_e   style;
    out_ready_r <= 1'b0;
    stretch_left = 0;
    hold_left    = 0;
    held         = 1'b0;
    style        = RX_STEADY;
    forever begin
      @(posedge clk);
      if (!held && hold_req) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (stretch_left == 0) begin
        style        = rx_style_e'($urandom_range(0, 3));
        stretch_left = $urandom_range(8, 80);
      end
      stretch_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_r <= 1'b0;
      end else begin
        case (style)
          RX_STEADY: out_ready_r <= 1'b1;
          RX_HALF:   out_ready_r <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_r <= ($urandom_range(0, 3) == 0);
          default:   out_ready_r <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready_r) sb.check_row(out_item);
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    mode_e                m;
    logic [RADIUS_W-1:0]  r;
    logic [WIDTH_W-1:0]   w;
    int unsigned          masks;
    int unsigned          len;
    sb = new();
    hold_req = 1'b0;
    rst_n      <= 1'b0;
    cfg_we_r   <= 1'b0;
    cfg_idx_r  <= CFG_MODE;
    cfg_data_r <= '0;
    in_valid_r <= 1'b0;
    in_item_r  <= '0;
    burst_left = 0;
    random_rows = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: dilation, radius zero, full width.
    send_row('0, 1'b0);
    send_row('1, 1'b0);
    send_row(64'h1, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b1);

    // Largest radius with masks shorter than the radius.
    write_cfg(MODE_DILATE, 4'd15, 7'd64);
    send_row(64'h0000_0001_0000_0000, 1'b1);
    send_row(64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
    send_row(64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
    send_row(64'h1, 1'b1);

    write_cfg(MODE_ERODE, 4'd1, 7'd64);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row(~(64'd1 << 20), 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // No column in use: every row comes out empty.
    write_cfg(MODE_ERODE, 4'd2, 7'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // Width above the maximum saturates.
    write_cfg(MODE_DILATE, 4'd3, 7'd127);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('0, 1'b0);
    send_row('0, 1'b1);

    write_cfg(MODE_ERODE, 4'd0, 7'd1);
    send_row(64'h3, 1'b0);
    send_row('1, 1'b1);

    // The receiver holds off while a long mask keeps coming, so the block fills.
    write_cfg(MODE_DILATE, 4'd0, 7'd64);
    hold_req = 1'b1;
    for (int unsigned i = 1; i <= HOLD_ROWS; i++) begin
      send_row(pick_row(ROW_RANDOM), i == HOLD_ROWS);
    end

    while (random_rows < RANDOM_ROWS) begin
      m = mode_e'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       r = 4'd0;
        1:       r = 4'd15;
        default: r = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        0:       w = 7'd0;
        1:       w = 7'($urandom_range(65, 127));
        2, 3:    w = 7'd64;
        default: w = 7'($urandom_range(1, 63));
      endcase
      write_cfg(m, r, w);
      masks = $urandom_range(1, 3);
      repeat (masks) begin
        // Mostly masks around the window height, sometimes long enough to wrap.
        if ($urandom_range(0, 6) == 0) len = $urandom_range(32, 40);
        else len = $urandom_range(1, 2 * r + 6);
        for (int unsigned i = 1; i <= len; i++) begin
          send_row(pick_row(style_for(m)), i == len);
          random_rows++;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    sb.check_end();
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bbmr_pkg.sv
rtl/core/bbmr_hlane.sv
rtl/core/bbmr_merge.sv
rtl/core/binary_box_morphology_rows.sv
tb/sv/bbmr_tb_pkg.sv
tb/sv/tb.sv
